@@ design/modexp_pkg.sv @@
// Shared widths and constants for the modular exponentiation block.
package modexp_pkg;

    localparam int FIELD_WIDTH = 32;
    localparam int CFG_WIDTH   = 32;

    localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;

endpackage

@@ design/modexp_modmul.sv @@
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module modexp_modmul #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] mult_a,
    input  logic [OPERAND_WIDTH-1:0] mult_b,
    input  logic [OPERAND_WIDTH:0]   modulus,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] product
);
    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     a_sr_reg;
    logic [W-1:0]     b_reg;
    logic [W:0]       m_reg;
    logic [W-1:0]     r_reg;
    logic [W-1:0]     r_next;

    logic [W+1:0] mod_w;
    logic [W+1:0] dbl;
    logic [W+1:0] dbl_red;
    logic [W+1:0] sum;
    logic [W+1:0] sum_red;

    always_comb
    begin
        mod_w   = {1'b0, m_reg};
        dbl     = {1'b0, r_reg, 1'b0};
        dbl_red = (dbl >= mod_w) ? (dbl - mod_w) : dbl;
        sum     = dbl_red + (a_sr_reg[W-1] ? {2'b00, b_reg} : '0);
        sum_red = (sum >= mod_w) ? (sum - mod_w) : sum;
        r_next  = sum_red[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(OPERAND_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sr_reg <= mult_a;
            b_reg    <= mult_b;
            m_reg    <= modulus;
            r_reg    <= '0;
        end
        else if (busy_reg)
        begin
            a_sr_reg <= {a_sr_reg[W-2:0], 1'b0};
            r_reg    <= r_next;
        end
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

@@ design/modular_exponentiation.sv @@
// Top level: square-and-multiply sequencer, modulus register and result register.
//
// Computes base_value to the power exponent modulo the configured modulus, using the
// low OPERAND_WIDTH bits of each. A modulus of zero acts as 2^OPERAND_WIDTH; an
// exponent of zero gives 1. One request is in work at a time; a finished result
// waits in its own register, so the next request is taken while it is pending.
// All products come from one bit-serial modular multiplier that handles one multiplier
// bit per cycle. A request takes one product to reduce the base, then, from the lowest
// exponent bit up to the highest set one, a multiply for each set bit and a squaring
// for each bit; a zero exponent takes the reduction alone.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  modexp_pkg::cfg_word_t  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  modexp_pkg::field_t     base_value,
    input  modexp_pkg::field_t     exponent,
    output logic                   out_valid,
    input  logic                   out_stall,
    output modexp_pkg::field_t     power_result
);
    import modexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    cfg_word_t  modulus_reg;
    logic [2:0] state_reg,  state_next;
    logic       start_reg,  start_next;
    logic [W-1:0] mul_a_reg, mul_a_next;
    logic [W-1:0] mul_b_reg, mul_b_next;
    logic [W:0]   mod_reg,   mod_next;
    logic [W-1:0] exp_reg,   exp_next;
    logic [W-1:0] acc_reg,   acc_next;
    logic [W-1:0] pw_reg,    pw_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] result_reg,    result_next;

    logic [W-1:0] mod_masked;
    logic [W:0]   mod_ext;
    logic [W-1:0] one_red;
    logic         mul_done;
    logic [W-1:0] mul_product;

    always_comb
    begin
        mod_masked = modulus_reg[W-1:0];
        mod_ext    = (mod_masked == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_masked};
        one_red    = (mod_ext == (W+1)'(1)) ? '0 : W'(1);
    end

    modexp_modmul #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .mult_a (mul_a_reg),
        .mult_b (mul_b_reg),
        .modulus(mod_reg),
        .done   (mul_done),
        .product(mul_product)
    );

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mod_next       = mod_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        pw_next        = pw_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next = 1'b1;
                    mul_a_next = base_value[W-1:0];
                    mul_b_next = one_red;
                    mod_next   = mod_ext;
                    exp_next   = exponent[W-1:0];
                    acc_next   = W'(1);
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                if (mul_done)
                begin
                    pw_next    = mul_product;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                start_next = (exp_reg != '0);
                if (exp_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (exp_reg[0])
                begin
                    mul_a_next = acc_reg;
                    mul_b_next = pw_reg;
                    state_next = S_MUL;
                end
                else
                begin
                    mul_a_next = pw_reg;
                    mul_b_next = pw_reg;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_product;
                    start_next = 1'b1;
                    mul_a_next = pw_reg;
                    mul_b_next = pw_reg;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mul_done)
                begin
                    pw_next    = mul_product;
                    exp_next   = exp_reg >> 1;
                    state_next = S_TEST;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET;
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        mod_reg    <= mod_next;
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        pw_reg     <= pw_next;
        result_reg <= result_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = FIELD_WIDTH'(result_reg);

endmodule

@@ design/modexp_checker.sv @@
// Port-level checks for the modular exponentiation block, with its bind.
module modexp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input modexp_pkg::field_t    power_result
);
    import modexp_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(power_result))
        else $error("stalled result changed or dropped");

    // block further requests once one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in work");

    // deliver a result only at the end of a request in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result appeared without a request in work");

    // no result in the cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

@@ tb/sv/tb_modular_exponentiation.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the modular exponentiation block.
module tb_modular_exponentiation;
    import modexp_pkg::*;

    localparam int OPW = 32;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    cfg_word_t cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    field_t    base_value = '0;
    field_t    exponent = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    field_t    power_result;

    class modexp_ledger;
        field_t          expected_powers[$];
        cfg_word_t       modulus;
        longint unsigned mask;
        int              errors;

        function new();
            modulus = MODULUS_RESET;
            mask = (64'd1 << OPW) - 64'd1;
            errors = 0;
        endfunction

        function longint unsigned reduce_mod(longint unsigned x, longint unsigned m);
            if (m == 0)
                return x & mask;
            return x % m;
        endfunction

        function field_t predict_power(field_t b, field_t e);
            longint unsigned m;
            longint unsigned acc;
            longint unsigned pw;
            field_t          bits;
            m = modulus & mask;
            acc = 1;
            pw = reduce_mod(b & mask, m);
            bits = field_t'(e & mask);
            while (bits != 0)
            begin
                if (bits[0])
                    acc = reduce_mod(acc * pw, m);
                pw = reduce_mod(pw * pw, m);
                bits = bits >> 1;
            end
            return acc[FIELD_WIDTH-1:0];
        endfunction

        function void note_request(field_t b, field_t e);
            expected_powers.push_back(predict_power(b, e));
        endfunction

        function void check_result(field_t got);
            field_t want;
            if (expected_powers.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: got %h", got);
            end
            else
            begin
                want = expected_powers.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("power_result mismatch: expected %h, actual %h", want, got);
                end
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    modexp_ledger ledger;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_stretch = 0;
    int stall_hold = 0;

    modular_exponentiation #(
        .OPERAND_WIDTH(OPW)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .base_value  (base_value),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .power_result(power_result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #30000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_result(power_result);
    end

    always @(posedge clk)
    begin
        if (stall_stretch == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_stretch = $urandom_range(20, 300);
        end
        stall_stretch--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_hold == 0)
                begin
                    out_stall <= ~out_stall;
                    stall_hold = $urandom_range(1, 30);
                end
                else
                    stall_hold--;
            end
        endcase
    end

    // drop valid, drain outstanding requests, then load the modulus
    task automatic write_modulus(input cfg_word_t m);
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        ledger.modulus = m;
    endtask

    task automatic issue_request(input field_t b, input field_t e);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(100, 2500);
            else
                gap = $urandom_range(1, 40);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 6);
        end
        in_valid <= 1'b1;
        base_value <= b;
        exponent <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_request(b, e);
        burst_left--;
    endtask

    initial
    begin
        cfg_word_t m;
        field_t    b;
        field_t    e;
        int        len;
        ledger = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(32'h0, 32'h0);
        issue_request(32'h0, 32'h1);
        issue_request(32'hFFFF_FFFF, 32'h0);
        issue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(32'h1, 32'hFFFF_FFFF);
        issue_request(32'h2, 32'd10);
        issue_request(32'd1000000007, 32'd5);
        issue_request(32'd1000000008, 32'd3);
        issue_request(32'h2, 32'h8000_0000);
        issue_request(32'hFFFF_FFFF, 32'h1);
        issue_request(32'hAAAA_AAAA, 32'h5555_5555);
        issue_request(32'h5555_5555, 32'hAAAA_AAAA);
        issue_request(32'd7, 32'd1000000006);

        write_modulus(32'd1);
        issue_request(32'd5, 32'h0);
        issue_request(32'hFFFF_FFFF, 32'd7);

        write_modulus(32'd0);
        issue_request(32'hFFFF_FFFF, 32'd2);
        issue_request(32'd3, 32'd40);
        issue_request(32'h0001_0000, 32'd2);
        issue_request(32'd5, 32'h0);

        write_modulus(32'hFFFF_FFFF);
        issue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        issue_request(32'hFFFF_FFFF, 32'd3);
        issue_request(32'h2, 32'd64);

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: m = $urandom;
                1: m = 32'hFFFF_FFFF;
                2: m = $urandom_range(2, 1000);
                3: m = MODULUS_RESET;
                4: m = 32'd0;
                5: m = $urandom | 32'h8000_0000;
                default: m = 32'd2;
            endcase
            write_modulus(m);
            for (int i = 0; i < 37; i++)
            begin
                case ($urandom_range(0, 3))
                    0: b = $urandom_range(0, 15);
                    1: b = 32'hFFFF_FFFF - $urandom_range(0, 15);
                    default: b = $urandom;
                endcase
                len = $urandom_range(0, 32);
                if (len == 0)
                    e = '0;
                else
                    e = $urandom >> (32 - len);
                issue_request(b, e);
            end
        end

        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
